### sv/mcbs_pkg.sv
// Shared types, constants and helpers for the molecule centroid box scale unit.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package mcbs_pkg;

  localparam int ID_W    = 20;
  localparam int POS_W   = 32;
  localparam int SUM_W   = 40;
  localparam int REG_W   = 31;
  localparam int DIV_W   = 40;
  localparam int NUM_AX  = 3;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int DEF_MAX_MOL_ATOMS = 64;
  localparam int DEF_ATOM_ID_BITS  = 20;

  localparam logic [REG_W-1:0] BOX_RESET   = REG_W'(65536);
  localparam logic [REG_W-1:0] SCALE_RESET = REG_W'(1073741824);
  localparam logic signed [32:0] Q30_ONE   = 33'sd1073741824;

  localparam logic [2:0] REG_BOX_X   = 3'd0;
  localparam logic [2:0] REG_BOX_Y   = 3'd1;
  localparam logic [2:0] REG_BOX_Z   = 3'd2;
  localparam logic [2:0] REG_SCALE_X = 3'd3;
  localparam logic [2:0] REG_SCALE_Y = 3'd4;
  localparam logic [2:0] REG_SCALE_Z = 3'd5;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]         atom_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    mol_end;
  } atom_in_t;

  typedef struct packed {
    logic [ID_W-1:0]         out_atom_id;
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic signed [POS_W-1:0] new_z;
    logic                    out_mol_end;
    logic                    too_many;
  } atom_out_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       div1_start;
    logic       div1_fix;
    logic       div2_start;
    logic       div2_fix;
    logic       nowrap;
    logic       mul;
    logic       shift;
    logic       zero_shift;
    logic       idx_clear;
    logic       idx_inc;
    logic       rd;
    logic       out_load;
    logic [1:0] ax;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic ovf;
    logic box_zero;
    logic last;
  } dp_status_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [POS_W+8:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 41'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -41'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/mcbs_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on mcbs_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module mcbs_div (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [mcbs_pkg::DIV_W-1:0]   dividend_i,
  input  wire  [mcbs_pkg::REG_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [mcbs_pkg::DIV_W-1:0]   quot_o,
  output logic [mcbs_pkg::REG_W-1:0]   rem_o
);
  import mcbs_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_q;
  logic [REG_W-1:0] rem_q, dvr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [REG_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    ge    = trial >= {1'b0, dvr_q};
    diff  = trial - {1'b0, dvr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[REG_W-1:0] : trial[REG_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### sv/mcbs_dp.sv
// Datapath: atom buffer, coordinate sums, centroid and wrap arithmetic, output register.
// Depends on mcbs_pkg and mcbs_div; driven by commands from mcbs_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mcbs_dp #(
  parameter int MAX_MOL_ATOMS = mcbs_pkg::DEF_MAX_MOL_ATOMS,
  parameter int ATOM_ID_BITS  = mcbs_pkg::DEF_ATOM_ID_BITS
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  mcbs_pkg::dp_cmd_t           cmd_i,
  output mcbs_pkg::dp_status_t        status_o,
  input  mcbs_pkg::atom_in_t          in_data_i,
  output mcbs_pkg::atom_out_t         out_data_o,
  input  wire  [mcbs_pkg::REG_W-1:0]  box_i   [mcbs_pkg::NUM_AX],
  input  wire  [mcbs_pkg::REG_W-1:0]  scale_i [mcbs_pkg::NUM_AX]
);
  import mcbs_pkg::*;

  localparam int IDW = (ATOM_ID_BITS < ID_W) ? ATOM_ID_BITS : ID_W;
  localparam int MW  = IDW + 3 * POS_W;
  localparam int CW  = $clog2(MAX_MOL_ATOMS + 1);
  localparam int AW  = (MAX_MOL_ATOMS > 1) ? $clog2(MAX_MOL_ATOMS) : 1;

  logic [MW-1:0]           mem [MAX_MOL_ATOMS];
  logic [MW-1:0]           rd_q;
  logic signed [SUM_W-1:0] sum_q [NUM_AX];
  logic signed [SUM_W-1:0] shift_q [NUM_AX];
  logic [CW-1:0]           cnt_q, idx_q;
  logic                    ovf_q, neg_q;
  logic signed [31:0]      c_q;
  logic signed [32:0]      w_q, off_q;
  logic signed [65:0]      prod_q;
  atom_out_t               out_q;

  logic                    room;
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        mag1;
  logic [31:0]             cmag;
  logic [DIV_W-1:0]        dividend, quot;
  logic [REG_W-1:0]        divisor, rem, box_sel, wv;
  logic                    div_done;
  logic signed [40:0]      qs, cfix;
  logic signed [32:0]      sf;
  logic signed [65:0]      prod_d, sh;
  logic signed [POS_W+8:0] tx, ty, tz;

  assign room    = cnt_q < CW'(MAX_MOL_ATOMS);
  assign sum_sel = sum_q[cmd_i.ax];
  assign box_sel = box_i[cmd_i.ax];
  assign mag1    = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
  assign cmag    = c_q[31] ? 32'(-c_q) : 32'(c_q);

  always_comb begin
    if (cmd_i.div2_start) begin
      dividend = DIV_W'(cmag);
      divisor  = box_sel;
    end else begin
      dividend = mag1;
      divisor  = REG_W'(cnt_q);
    end
    qs   = $signed({1'b0, quot});
    cfix = neg_q ? (-qs - 41'(rem != '0)) : qs;
    if (!neg_q) begin
      wv = rem;
    end else if (rem == '0) begin
      wv = '0;
    end else begin
      wv = box_sel - rem;
    end
    sf     = $signed({2'b00, scale_i[cmd_i.ax]}) - Q30_ONE;
    prod_d = 66'(w_q) * 66'(sf);
    sh     = prod_q >>> 30;
    tx     = 41'($signed(rd_q[3*POS_W-1 -: POS_W])) + 41'(shift_q[0]);
    ty     = 41'($signed(rd_q[2*POS_W-1 -: POS_W])) + 41'(shift_q[1]);
    tz     = 41'($signed(rd_q[POS_W-1:0])) + 41'(shift_q[2]);
  end

  mcbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div1_start | cmd_i.div2_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // control state: count, emit index, overflow flag, sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      ovf_q <= 1'b0;
      for (int a = 0; a < NUM_AX; a++) begin
        sum_q[a] <= '0;
      end
    end else begin
      if (cmd_i.clear) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
        for (int a = 0; a < NUM_AX; a++) begin
          sum_q[a] <= '0;
        end
      end else if (cmd_i.load) begin
        if (room) begin
          cnt_q    <= cnt_q + 1'b1;
          sum_q[0] <= sum_q[0] + SUM_W'(in_data_i.pos_x);
          sum_q[1] <= sum_q[1] + SUM_W'(in_data_i.pos_y);
          sum_q[2] <= sum_q[2] + SUM_W'(in_data_i.pos_z);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.idx_clear) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      mem[cnt_q[AW-1:0]] <= {in_data_i.atom_id[IDW-1:0], in_data_i.pos_x,
                             in_data_i.pos_y, in_data_i.pos_z};
    end
    if (cmd_i.rd) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div1_start) begin
      neg_q <= sum_sel[SUM_W-1];
    end else if (cmd_i.div2_start) begin
      neg_q <= c_q[31];
    end
    if (cmd_i.div1_fix) begin
      c_q <= cfix[31:0];
    end
    if (cmd_i.nowrap) begin
      w_q   <= 33'(c_q);
      off_q <= '0;
    end else if (cmd_i.div2_fix) begin
      w_q   <= $signed({2'b00, wv});
      off_q <= 33'(c_q) - $signed({2'b00, wv});
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.zero_shift) begin
      for (int a = 0; a < NUM_AX; a++) begin
        shift_q[a] <= '0;
      end
    end else if (cmd_i.shift) begin
      shift_q[cmd_i.ax] <= sh[SUM_W-1:0] - 40'(off_q);
    end
    if (cmd_i.out_load) begin
      out_q.out_atom_id <= ID_W'(rd_q[MW-1 -: IDW]);
      out_q.new_x       <= sat32(tx);
      out_q.new_y       <= sat32(ty);
      out_q.new_z       <= sat32(tz);
      out_q.out_mol_end <= status_o.last;
      out_q.too_many    <= ovf_q;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.ovf      = ovf_q;
  assign status_o.box_zero = (box_sel == '0);
  assign status_o.last     = (idx_q + 1'b1) == cnt_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

### sv/mcbs_ctrl.sv
// Controller: sequences loading, the per-axis centroid and wrap steps, and emission.
// Depends on mcbs_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mcbs_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   in_mol_end_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output mcbs_pkg::dp_cmd_t     cmd_o,
  input  mcbs_pkg::dp_status_t  status_i
);
  import mcbs_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_D1, S_D1W, S_D1F, S_WRAP, S_D2W, S_D2F,
    S_MUL, S_SHF, S_RD, S_CALC, S_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] ax_q;
  logic       out_valid_q;
  logic       in_beat, out_beat;

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_beat    = out_valid_q && !out_stall_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.ax         = ax_q;
    cmd_o.load       = in_beat;
    cmd_o.idx_clear  = (state_q == S_START);
    cmd_o.zero_shift = (state_q == S_START) && status_i.ovf;
    cmd_o.div1_start = (state_q == S_D1);
    cmd_o.div1_fix   = (state_q == S_D1F);
    cmd_o.nowrap     = (state_q == S_WRAP) && status_i.box_zero;
    cmd_o.div2_start = (state_q == S_WRAP) && !status_i.box_zero;
    cmd_o.div2_fix   = (state_q == S_D2F);
    cmd_o.mul        = (state_q == S_MUL);
    cmd_o.shift      = (state_q == S_SHF);
    cmd_o.rd         = (state_q == S_RD);
    cmd_o.out_load   = (state_q == S_CALC);
    cmd_o.clear      = (state_q == S_OUT) && out_beat && status_i.last;
    cmd_o.idx_inc    = (state_q == S_OUT) && out_beat && !status_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      ax_q        <= AX_X;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_beat && in_mol_end_i) begin
            state_q <= S_START;
          end
        end
        S_START: begin
          ax_q    <= AX_X;
          state_q <= status_i.ovf ? S_RD : S_D1;
        end
        S_D1:  state_q <= S_D1W;
        S_D1W: begin
          if (status_i.div_done) begin
            state_q <= S_D1F;
          end
        end
        S_D1F:  state_q <= S_WRAP;
        S_WRAP: state_q <= status_i.box_zero ? S_MUL : S_D2W;
        S_D2W: begin
          if (status_i.div_done) begin
            state_q <= S_D2F;
          end
        end
        S_D2F: state_q <= S_MUL;
        S_MUL: state_q <= S_SHF;
        S_SHF: begin
          if (ax_q == AX_Z) begin
            state_q <= S_RD;
          end else begin
            ax_q    <= ax_q + 1'b1;
            state_q <= S_D1;
          end
        end
        S_RD: state_q <= S_CALC;
        S_CALC: begin
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_beat) begin
            out_valid_q <= 1'b0;
            state_q     <= status_i.last ? S_LOAD : S_RD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  a_valid_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == S_OUT)
    else $error("result valid outside emit state");

  a_last_returns_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && status_i.last) |=> !in_stall_o)
    else $error("input not reopened after last result");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_D1W || state_q == S_D2W))
    else $error("divider finished while not awaited");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall_o)
    else $error("input open while emitting");

endmodule

`default_nettype wire

### sv/molecule_centroid_box_scale_unit.sv
// Top level of the molecule centroid box scale unit: register port and channels.
// Depends on mcbs_pkg, mcbs_ctrl, mcbs_dp (which holds mcbs_div).
//
// Atoms enter on the input channel (in_valid_i / in_stall_o), one beat each,
// grouped by molecule with mol_end set on the last atom. While loading, the
// input takes a new atom every clock. After the last atom each axis runs two
// serial divisions (centroid, then box wrap; the wrap is skipped for a zero
// box) through one shared divider and one multiply. The shifted atoms then
// leave on the output channel (out_valid_o / out_stall_i) in arrival order,
// one at a time, each read from the buffer's registered read port into the
// result register. The input stalls from the last atom until the molecule's
// last result beat. A stall on the output holds the result register and
// pauses emission. Atoms past the buffer depth are dropped and the molecule
// leaves unshifted with too_many set. Reset empties the molecule and loads
// the default box (1.0) and scale (1.0); registers are to be written through
// the APB port only while idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module molecule_centroid_box_scale_unit #(
  parameter int MAX_MOL_ATOMS = mcbs_pkg::DEF_MAX_MOL_ATOMS,
  parameter int ATOM_ID_BITS  = mcbs_pkg::DEF_ATOM_ID_BITS
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  mcbs_pkg::atom_in_t           in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output mcbs_pkg::atom_out_t          out_data_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [mcbs_pkg::ADDR_W-1:0]  paddr,
  input  wire  [mcbs_pkg::DATA_W-1:0]  pwdata,
  output logic [mcbs_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import mcbs_pkg::*;

  logic [REG_W-1:0] box_q   [NUM_AX];
  logic [REG_W-1:0] scale_q [NUM_AX];
  logic [2:0]       reg_idx;
  logic             wr_en;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AX; a++) begin
        box_q[a]   <= BOX_RESET;
        scale_q[a] <= SCALE_RESET;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_BOX_X:   box_q[0]   <= pwdata[REG_W-1:0];
        REG_BOX_Y:   box_q[1]   <= pwdata[REG_W-1:0];
        REG_BOX_Z:   box_q[2]   <= pwdata[REG_W-1:0];
        REG_SCALE_X: scale_q[0] <= pwdata[REG_W-1:0];
        REG_SCALE_Y: scale_q[1] <= pwdata[REG_W-1:0];
        REG_SCALE_Z: scale_q[2] <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BOX_X:   prdata = DATA_W'(box_q[0]);
      REG_BOX_Y:   prdata = DATA_W'(box_q[1]);
      REG_BOX_Z:   prdata = DATA_W'(box_q[2]);
      REG_SCALE_X: prdata = DATA_W'(scale_q[0]);
      REG_SCALE_Y: prdata = DATA_W'(scale_q[1]);
      REG_SCALE_Z: prdata = DATA_W'(scale_q[2]);
      default:     prdata = '0;
    endcase
  end

  mcbs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_mol_end_i (in_data_i.mol_end),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  mcbs_dp #(
    .MAX_MOL_ATOMS (MAX_MOL_ATOMS),
    .ATOM_ID_BITS  (ATOM_ID_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .box_i      (box_q),
    .scale_i    (scale_q)
  );

endmodule

`default_nettype wire
